FILE: design/icpc_pkg.sv
package icpc_pkg;

    // edge mode codes of a capture channel, also the edge code {old, new}
    typedef enum logic [1:0] {
        EDGE_OFF  = 2'd0,
        EDGE_RISE = 2'd1,
        EDGE_FALL = 2'd2,
        EDGE_ANY  = 2'd3
    } t_edge_mode;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_CAPTURE1_MODE  = 3'd0,
        CFG_CAPTURE2_MODE  = 3'd1,
        CFG_CAPTURE3_MODE  = 3'd2,
        CFG_COUNTER_ENABLE = 3'd3,
        CFG_COUNTER_GATED  = 3'd4,
        CFG_COUNTER_RISING = 3'd5
    } t_cfg_index;

    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth  = 2;
    localparam int unsigned PinWidth      = 3;
    localparam int unsigned NumPins       = 8;
    localparam int unsigned TimeWidth     = 16;
    localparam int unsigned CountWidth    = 8;
    localparam int unsigned NumChannels   = 3;

    // highest capture pin and the pulse counter pin
    localparam logic [PinWidth-1:0] LastCapturePin = 3'd2;
    localparam logic [PinWidth-1:0] CounterPin     = 3'd7;

    typedef logic [TimeWidth-1:0]  t_time;
    typedef logic [CountWidth-1:0] t_count;
    typedef logic [PinWidth-1:0]   t_pin;

    // capture unit status, hit index 0 is channel 1 (pin 2)
    typedef struct packed {
        logic [NumChannels-1:0] hit;
        t_time                  captured_time;
    } t_cap_status;

    // pulse counter status
    typedef struct packed {
        logic   edge_seen;
        logic   overflow;
        t_count pulse_count;
    } t_cnt_status;

    // one result item
    typedef struct packed {
        logic [NumPins-1:0] port_value;
        logic               capture1_hit;
        logic               capture2_hit;
        logic               capture3_hit;
        t_time              captured_time;
        logic               counter_edge_seen;
        logic               counter_overflow;
        t_count             pulse_count;
    } t_result;

endpackage

FILE: design/icpc_in_if.sv
interface icpc_in_if;
    logic                    valid;
    logic                    ready;
    icpc_pkg::t_pin          pin_number;
    logic                    pin_level;
    icpc_pkg::t_time         timer_count;

    modport source (output valid, output pin_number, output pin_level, output timer_count,
                    input ready);
    modport sink   (input valid, input pin_number, input pin_level, input timer_count,
                    output ready);
endinterface

FILE: design/icpc_out_if.sv
interface icpc_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [icpc_pkg::NumPins-1:0]          port_value;
    logic                                  capture1_hit;
    logic                                  capture2_hit;
    logic                                  capture3_hit;
    icpc_pkg::t_time                       captured_time;
    logic                                  counter_edge_seen;
    logic                                  counter_overflow;
    icpc_pkg::t_count                      pulse_count;

    modport source (output valid, output port_value, output capture1_hit,
                    output capture2_hit, output capture3_hit, output captured_time,
                    output counter_edge_seen, output counter_overflow,
                    output pulse_count, input ready);
    modport sink   (input valid, input port_value, input capture1_hit,
                    input capture2_hit, input capture3_hit, input captured_time,
                    input counter_edge_seen, input counter_overflow,
                    input pulse_count, output ready);
endinterface

FILE: design/icpc_capture.sv
module icpc_capture (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  icpc_pkg::t_pin         i_pin,
    input  logic                   i_level,
    input  logic                   i_old_level,
    input  icpc_pkg::t_time        i_timer_count,
    input  icpc_pkg::t_edge_mode   i_mode [icpc_pkg::NumChannels],
    output icpc_pkg::t_cap_status  o_status
);

    icpc_pkg::t_time  r_times [icpc_pkg::NumChannels];
    icpc_pkg::t_time  n_times [icpc_pkg::NumChannels];
    logic [1:0]       chan;
    logic             addressed;
    logic [1:0]       edge_code;
    logic             match;

    // pin 0 maps to channel 3 (entry 2), pin 2 to channel 1 (entry 0)
    always_comb begin
        addressed = (i_pin <= icpc_pkg::LastCapturePin);
        chan      = 2'(icpc_pkg::LastCapturePin - i_pin);
        edge_code = {i_old_level, i_level};
        match     = 1'b0;
        if (addressed && (edge_code == icpc_pkg::EDGE_RISE || edge_code == icpc_pkg::EDGE_FALL))
        begin
            match = (i_mode[chan] == icpc_pkg::t_edge_mode'(edge_code)) ||
                    (i_mode[chan] == icpc_pkg::EDGE_ANY);
        end
    end

    // capture register update and status
    always_comb begin
        n_times                 = r_times;
        o_status.hit            = '0;
        o_status.captured_time  = '0;
        if (match) begin
            n_times[chan]       = i_timer_count;
            o_status.hit[chan]  = 1'b1;
        end
        if (addressed) begin
            o_status.captured_time = n_times[chan];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < icpc_pkg::NumChannels; i++) begin
                r_times[i] <= '0;
            end
        end else if (i_accept) begin
            r_times <= n_times;
        end
    end

    // at most one channel latches per transfer
    a_hit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_status.hit))
        else $error("more than one capture hit");

    // a hit stores the timer value
    a_hit_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && match) |-> (o_status.captured_time == i_timer_count))
        else $error("capture hit does not report timer value");

endmodule

FILE: design/icpc_counter.sv
module icpc_counter (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  icpc_pkg::t_pin         i_pin,
    input  logic                   i_level,
    input  logic                   i_old_level,
    input  logic                   i_enable,
    input  logic                   i_gated,
    input  logic                   i_rising,
    output icpc_pkg::t_cnt_status  o_status
);

    icpc_pkg::t_count r_count;
    logic             count_edge;

    // counts only the selected edge of pin 7 in event mode
    always_comb begin
        count_edge = (i_pin == icpc_pkg::CounterPin) && i_enable && !i_gated &&
                     (i_old_level != i_level) && (i_rising != i_old_level);
        o_status.edge_seen   = count_edge;
        o_status.overflow    = count_edge && (r_count == '1);
        o_status.pulse_count = count_edge ? r_count + 1'b1 : r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= o_status.pulse_count;
        end
    end

    // each counted transfer advances the counter by one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && count_edge) |=> (r_count == $past(r_count) + 1'b1))
        else $error("pulse counter did not advance");

endmodule

FILE: design/icpc_skid.sv
module icpc_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  icpc_pkg::t_result  i_data,
    output logic               o_ready,
    icpc_out_if.source         o_out
);

    logic              r_main_valid;
    logic              r_skid_valid;
    icpc_pkg::t_result r_main;
    icpc_pkg::t_result r_skid;
    logic              n_main_valid;
    logic              n_skid_valid;
    icpc_pkg::t_result n_main;
    icpc_pkg::t_result n_skid;
    logic              pop;

    assign o_ready = !r_skid_valid;
    assign pop     = r_main_valid && o_out.ready;

    // two-entry output buffer, main entry drives the port
    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (pop || !r_main_valid) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_main_valid = 1'b1;
                n_skid       = i_data;
                n_skid_valid = i_push;
            end else begin
                n_main       = i_data;
                n_main_valid = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_out.valid             = r_main_valid;
    assign o_out.port_value        = r_main.port_value;
    assign o_out.capture1_hit      = r_main.capture1_hit;
    assign o_out.capture2_hit      = r_main.capture2_hit;
    assign o_out.capture3_hit      = r_main.capture3_hit;
    assign o_out.captured_time     = r_main.captured_time;
    assign o_out.counter_edge_seen = r_main.counter_edge_seen;
    assign o_out.counter_overflow  = r_main.counter_overflow;
    assign o_out.pulse_count       = r_main.pulse_count;

    // skid entry only holds data behind a waiting main entry
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry valid without main entry");

    // a stalled result moves to nothing else
    a_main_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_main_valid && !o_out.ready) |=> (r_main_valid && r_main == $past(r_main)))
        else $error("stalled result changed");

endmodule

FILE: design/input_capture_and_pulse_counter.sv
// Input capture and pulse counter. Each transfer on i_in drives a new level
// onto one port pin together with the timer count and yields one result on
// o_out. Pins 0..2 are capture channels 3..1, pin 7 drives the 8-bit pulse
// counter; writes to pins 3..6 are ignored. One transfer is taken every cycle
// while i_in.ready is high; its result is registered in the output buffer.
// The two-entry buffer keeps i_in.ready high for one more transfer while a
// result waits on o_out, so throughput is one item per cycle whenever the
// sink takes one per cycle. Configuration must be written through i_cfg_we,
// i_cfg_index and i_cfg_data while the block is idle; it is not enforced.
module input_capture_and_pulse_counter (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [icpc_pkg::CfgIndexWidth-1:0]    i_cfg_index,
    input  logic [icpc_pkg::CfgDataWidth-1:0]     i_cfg_data,
    icpc_in_if.sink                               i_in,
    icpc_out_if.source                            o_out
);

    icpc_pkg::t_edge_mode         r_mode [icpc_pkg::NumChannels];
    logic                         r_cnt_enable;
    logic                         r_cnt_gated;
    logic                         r_cnt_rising;
    logic [icpc_pkg::NumPins-1:0] r_pin_levels;
    logic [icpc_pkg::NumPins-1:0] n_pin_levels;
    logic                         accept;
    logic                         old_level;
    logic                         buf_ready;
    icpc_pkg::t_cap_status        cap_status;
    icpc_pkg::t_cnt_status        cnt_status;
    icpc_pkg::t_result            result;

    assign i_in.ready = buf_ready;
    assign accept     = i_in.valid && buf_ready;
    assign old_level  = r_pin_levels[i_in.pin_number];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < icpc_pkg::NumChannels; i++) begin
                r_mode[i] <= icpc_pkg::EDGE_OFF;
            end
            r_cnt_enable <= 1'b0;
            r_cnt_gated  <= 1'b0;
            r_cnt_rising <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (icpc_pkg::t_cfg_index'(i_cfg_index))
                icpc_pkg::CFG_CAPTURE1_MODE:  r_mode[0] <= icpc_pkg::t_edge_mode'(i_cfg_data);
                icpc_pkg::CFG_CAPTURE2_MODE:  r_mode[1] <= icpc_pkg::t_edge_mode'(i_cfg_data);
                icpc_pkg::CFG_CAPTURE3_MODE:  r_mode[2] <= icpc_pkg::t_edge_mode'(i_cfg_data);
                icpc_pkg::CFG_COUNTER_ENABLE: r_cnt_enable <= i_cfg_data[0];
                icpc_pkg::CFG_COUNTER_GATED:  r_cnt_gated  <= i_cfg_data[0];
                icpc_pkg::CFG_COUNTER_RISING: r_cnt_rising <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // pin levels, only capture pins and the counter pin follow the input
    always_comb begin
        n_pin_levels = r_pin_levels;
        if (i_in.pin_number <= icpc_pkg::LastCapturePin ||
            i_in.pin_number == icpc_pkg::CounterPin) begin
            n_pin_levels[i_in.pin_number] = i_in.pin_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_levels <= '0;
        end else if (accept) begin
            r_pin_levels <= n_pin_levels;
        end
    end

    icpc_capture u_capture (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_pin         (i_in.pin_number),
        .i_level       (i_in.pin_level),
        .i_old_level   (old_level),
        .i_timer_count (i_in.timer_count),
        .i_mode        (r_mode),
        .o_status      (cap_status)
    );

    icpc_counter u_counter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_pin       (i_in.pin_number),
        .i_level     (i_in.pin_level),
        .i_old_level (old_level),
        .i_enable    (r_cnt_enable),
        .i_gated     (r_cnt_gated),
        .i_rising    (r_cnt_rising),
        .o_status    (cnt_status)
    );

    // assemble the result item
    always_comb begin
        result.port_value        = n_pin_levels;
        result.capture1_hit      = cap_status.hit[0];
        result.capture2_hit      = cap_status.hit[1];
        result.capture3_hit      = cap_status.hit[2];
        result.captured_time     = cap_status.captured_time;
        result.counter_edge_seen = cnt_status.edge_seen;
        result.counter_overflow  = cnt_status.overflow;
        result.pulse_count       = cnt_status.pulse_count;
    end

    icpc_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (result),
        .o_ready (buf_ready),
        .o_out   (o_out)
    );

    // unused pins never leave their reset level
    a_unused_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pin_levels[6:3] == '0)
        else $error("pins three to six changed level");

endmodule

FILE: bench/tb_input_capture_and_pulse_counter.sv
`timescale 1ns / 1ps

module tb_input_capture_and_pulse_counter;

    localparam int ClkHalfNs     = 6;
    localparam int ClkPeriodNs   = 2 * ClkHalfNs;
    localparam int TimeoutCycles = 400_000;
    localparam int RandomItems   = 1450;
    localparam int PulseToggles  = 512;
    localparam int MaxErrorLines = 100;

    typedef struct {
        icpc_pkg::t_pin  pin;
        logic            level;
        icpc_pkg::t_time tcount;
    } t_pin_write;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               cfg_we;
    logic [icpc_pkg::CfgIndexWidth-1:0] cfg_index;
    logic [icpc_pkg::CfgDataWidth-1:0]  cfg_data;

    icpc_in_if  in_bus ();
    icpc_out_if out_bus ();

    input_capture_and_pulse_counter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_bus),
        .o_out       (out_bus)
    );

    // pending pin writes and the results they must produce
    t_pin_write          pin_write_q[$];
    icpc_pkg::t_result   expected_result_q[$];
    int         items_queued   = 0;
    int         items_accepted = 0;
    int         results_seen   = 0;
    int         error_count    = 0;
    int         counted        = 0;
    int         send_idle_pct  = 0;
    int         recv_idle_pct  = 0;

    // pin levels as seen by the stimulus generator
    logic [icpc_pkg::NumPins-1:0] gen_levels = '0;

    // predictor copy of the configuration
    icpc_pkg::t_edge_mode cap_mode [icpc_pkg::NumChannels] = '{default: icpc_pkg::EDGE_OFF};
    logic       cnt_enable = 1'b0;
    logic       cnt_gated  = 1'b0;
    logic       cnt_rising = 1'b0;

    // predictor copy of the block state
    logic [icpc_pkg::NumPins-1:0] pin_state = '0;
    icpc_pkg::t_time              cap_time [icpc_pkg::NumChannels] = '{default: '0};
    icpc_pkg::t_count             pulse_cnt = '0;

    always begin
        #ClkHalfNs i_clk = 1'b1;
        #ClkHalfNs i_clk = 1'b0;
    end

    // next port state, capture and pulse count for one pin write
    function automatic icpc_pkg::t_result predict_pin_update(icpc_pkg::t_pin pin, logic level,
                                                            icpc_pkg::t_time tcount);
        icpc_pkg::t_result                r;
        logic                             old_lvl;
        logic [1:0]                       edge_code;
        logic [icpc_pkg::NumChannels-1:0] hit;
        int                               ch;
        r         = '0;
        hit       = '0;
        old_lvl   = pin_state[pin];
        edge_code = {old_lvl, level};
        if (pin <= icpc_pkg::LastCapturePin) begin
            // pin 2 is channel 1, pin 0 is channel 3
            ch = int'(icpc_pkg::LastCapturePin) - int'(pin);
            if ((edge_code == icpc_pkg::EDGE_RISE || edge_code == icpc_pkg::EDGE_FALL) &&
                (cap_mode[ch] == icpc_pkg::EDGE_ANY || cap_mode[ch] == edge_code)) begin
                cap_time[ch] = tcount;
                hit[ch]      = 1'b1;
            end
            r.captured_time = cap_time[ch];
            pin_state[pin]  = level;
        end else if (pin == icpc_pkg::CounterPin) begin
            pin_state[pin] = level;
            if (cnt_enable && !cnt_gated && old_lvl != level && cnt_rising != old_lvl) begin
                r.counter_edge_seen = 1'b1;
                pulse_cnt           = pulse_cnt + 1'b1;
                r.counter_overflow  = (pulse_cnt == '0);
            end
        end
        r.port_value   = pin_state;
        r.capture1_hit = hit[0];
        r.capture2_hit = hit[1];
        r.capture3_hit = hit[2];
        r.pulse_count  = pulse_cnt;
        return r;
    endfunction

    task automatic report_error(string msg);
        if (error_count < MaxErrorLines)
            $display("[%0t] ERROR: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_error($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                   results_seen, name, got, want));
    endtask

    // input driver: one transfer per accepted item, random gaps
    always @(posedge i_clk) begin
        t_pin_write nxt;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                expected_result_q.push_back(predict_pin_update(in_bus.pin_number,
                                                               in_bus.pin_level,
                                                               in_bus.timer_count));
                items_accepted++;
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (pin_write_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pin_write_q.pop_front();
                    in_bus.valid       <= 1'b1;
                    in_bus.pin_number  <= nxt.pin;
                    in_bus.pin_level   <= nxt.level;
                    in_bus.timer_count <= nxt.tcount;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge i_clk) begin
        icpc_pkg::t_result want;
        out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (expected_result_q.size() == 0) begin
                report_error($sformatf("result %0d arrived with none expected", results_seen));
            end else begin
                want = expected_result_q.pop_front();
                check_field("port_value", out_bus.port_value, want.port_value);
                check_field("capture1_hit", out_bus.capture1_hit, want.capture1_hit);
                check_field("capture2_hit", out_bus.capture2_hit, want.capture2_hit);
                check_field("capture3_hit", out_bus.capture3_hit, want.capture3_hit);
                check_field("captured_time", out_bus.captured_time, want.captured_time);
                check_field("counter_edge_seen", out_bus.counter_edge_seen,
                            want.counter_edge_seen);
                check_field("counter_overflow", out_bus.counter_overflow,
                            want.counter_overflow);
                check_field("pulse_count", out_bus.pulse_count, want.pulse_count);
            end
            results_seen++;
        end
    end

    task automatic queue_write(icpc_pkg::t_pin pin, logic level, icpc_pkg::t_time tcount);
        t_pin_write w;
        w.pin    = pin;
        w.level  = level;
        w.tcount = tcount;
        pin_write_q.push_back(w);
        items_queued++;
        if (pin <= icpc_pkg::LastCapturePin || pin == icpc_pkg::CounterPin)
            gen_levels[pin] = level;
    endtask

    // mostly real edges on the capture and counter pins, some noise
    task automatic queue_random_write();
        int             r;
        icpc_pkg::t_pin pin;
        logic           level;
        r = $urandom_range(99);
        if (r < 45)
            pin = icpc_pkg::t_pin'($urandom_range(icpc_pkg::LastCapturePin));
        else if (r < 85)
            pin = icpc_pkg::CounterPin;
        else
            pin = icpc_pkg::t_pin'($urandom_range(icpc_pkg::CounterPin - 1,
                                                  icpc_pkg::LastCapturePin + 1));
        if (pin > icpc_pkg::LastCapturePin && pin != icpc_pkg::CounterPin) begin
            level = 1'($urandom_range(1));
        end else begin
            level = ($urandom_range(3) != 0) ? !gen_levels[pin] : 1'($urandom_range(1));
        end
        counted++;
        queue_write(pin, level, icpc_pkg::t_time'($urandom_range(16'hFFFF)));
    endtask

    // all transfers done and every result back
    task automatic wait_until_idle();
        while (items_accepted != items_queued || expected_result_q.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_register(logic [icpc_pkg::CfgIndexWidth-1:0] idx,
                                  logic [icpc_pkg::CfgDataWidth-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            icpc_pkg::CFG_CAPTURE1_MODE:  cap_mode[0] = icpc_pkg::t_edge_mode'(data);
            icpc_pkg::CFG_CAPTURE2_MODE:  cap_mode[1] = icpc_pkg::t_edge_mode'(data);
            icpc_pkg::CFG_CAPTURE3_MODE:  cap_mode[2] = icpc_pkg::t_edge_mode'(data);
            icpc_pkg::CFG_COUNTER_ENABLE: cnt_enable  = data[0];
            icpc_pkg::CFG_COUNTER_GATED:  cnt_gated   = data[0];
            icpc_pkg::CFG_COUNTER_RISING: cnt_rising  = data[0];
            default: ;
        endcase
    endtask

    // full register setting; upper data bit of one-bit registers is junk
    task automatic program_setting(icpc_pkg::t_edge_mode m1, icpc_pkg::t_edge_mode m2,
                                   icpc_pkg::t_edge_mode m3,
                                   logic en, logic gated, logic rising);
        write_register(icpc_pkg::CFG_CAPTURE1_MODE, m1);
        write_register(icpc_pkg::CFG_CAPTURE2_MODE, m2);
        write_register(icpc_pkg::CFG_CAPTURE3_MODE, m3);
        write_register(icpc_pkg::CFG_COUNTER_ENABLE, {1'($urandom_range(1)), en});
        write_register(icpc_pkg::CFG_COUNTER_GATED, {1'($urandom_range(1)), gated});
        write_register(icpc_pkg::CFG_COUNTER_RISING, {1'($urandom_range(1)), rising});
        // unused indexes must not disturb anything
        for (int k = int'(icpc_pkg::CFG_COUNTER_RISING) + 1;
             k < (1 << icpc_pkg::CfgIndexWidth); k++)
            write_register(icpc_pkg::CfgIndexWidth'(k),
                           icpc_pkg::CfgDataWidth'($urandom_range(3)));
    endtask

    task automatic set_idle_profile();
        if (counted < RandomItems / 3) begin
            send_idle_pct = 27;
            recv_idle_pct = 66;
        end else if (counted < 2 * RandomItems / 3) begin
            send_idle_pct = 66;
            recv_idle_pct = 27;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    // one random phase; the sender holds off halfway until all results are in
    task automatic run_phase(bit pulse_train, int n);
        for (int k = 0; k < n; k++) begin
            if (k == n / 2)
                wait_until_idle();
            if (pulse_train) begin
                queue_write(icpc_pkg::CounterPin, !gen_levels[icpc_pkg::CounterPin],
                            icpc_pkg::t_time'($urandom_range(16'hFFFF)));
                counted++;
                if ($urandom_range(9) < 3)
                    queue_random_write();
            end else begin
                queue_random_write();
            end
        end
    endtask

    // stimulus and end of test
    initial begin
        int phase;
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        in_bus.valid       = 1'b0;
        in_bus.pin_number  = '0;
        in_bus.pin_level   = 1'b0;
        in_bus.timer_count = '0;
        out_bus.ready      = 1'b0;
        send_idle_pct      = 27;
        recv_idle_pct      = 66;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting: channels off, counter disabled, pins 3..6 ignored
        queue_write(3'd0, 1'b1, 16'hFFFF);
        queue_write(icpc_pkg::LastCapturePin, 1'b1, 16'h0000);
        queue_write(icpc_pkg::CounterPin, 1'b1, 16'h0001);
        queue_write(icpc_pkg::CounterPin, 1'b0, 16'h0002);
        queue_write(3'd3, 1'b1, 16'h8000);
        queue_write(3'd0, 1'b0, 16'h7FFF);
        queue_write(icpc_pkg::LastCapturePin, 1'b0, 16'h0003);
        wait_until_idle();

        // one channel per edge mode, counter on rising edges
        program_setting(icpc_pkg::EDGE_RISE, icpc_pkg::EDGE_FALL, icpc_pkg::EDGE_ANY,
                        1'b1, 1'b0, 1'b1);
        queue_write(icpc_pkg::LastCapturePin, 1'b1, 16'hFFFF);
        queue_write(icpc_pkg::LastCapturePin, 1'b1, 16'h1234);
        queue_write(icpc_pkg::LastCapturePin, 1'b0, 16'h0000);
        queue_write(3'd1, 1'b1, 16'h00AA);
        queue_write(3'd1, 1'b0, 16'h0000);
        queue_write(3'd0, 1'b1, 16'hFFFF);
        queue_write(3'd0, 1'b0, 16'h5555);
        queue_write(3'd0, 1'b0, 16'hAAAA);
        queue_write(3'd4, 1'b1, 16'h0F0F);
        queue_write(3'd5, 1'b1, 16'hF0F0);
        queue_write(3'd6, 1'b1, 16'h00FF);
        queue_write(icpc_pkg::CounterPin, 1'b1, 16'h0010);
        queue_write(icpc_pkg::CounterPin, 1'b1, 16'h0011);
        queue_write(icpc_pkg::CounterPin, 1'b0, 16'h0012);
        queue_write(icpc_pkg::CounterPin, 1'b1, 16'h0013);
        wait_until_idle();

        // random phases; the first is a long pulse train that wraps the counter
        phase = 0;
        while (counted < RandomItems) begin
            set_idle_profile();
            if (phase == 0)
                program_setting(icpc_pkg::t_edge_mode'($urandom_range(3)),
                                icpc_pkg::t_edge_mode'($urandom_range(3)),
                                icpc_pkg::t_edge_mode'($urandom_range(3)), 1'b1, 1'b0,
                                1'($urandom_range(1)));
            else if (phase == 1)
                program_setting(icpc_pkg::EDGE_ANY, icpc_pkg::EDGE_ANY, icpc_pkg::EDGE_ANY,
                                1'b1, 1'b1, 1'b1);
            else if (phase == 2)
                program_setting(icpc_pkg::EDGE_OFF, icpc_pkg::EDGE_OFF, icpc_pkg::EDGE_OFF,
                                1'b0, 1'b0, 1'b0);
            else
                program_setting(icpc_pkg::t_edge_mode'($urandom_range(3)),
                                icpc_pkg::t_edge_mode'($urandom_range(3)),
                                icpc_pkg::t_edge_mode'($urandom_range(3)),
                                ($urandom_range(3) != 0),
                                ($urandom_range(3) == 0), 1'($urandom_range(1)));
            run_phase(phase == 0, (phase == 0) ? PulseToggles : $urandom_range(120, 200));
            wait_until_idle();
            phase++;
        end

        repeat (4) @(posedge i_clk);
        if (expected_result_q.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_result_q.size()));
        if (error_count == 0) begin
            $display("** input_capture_and_pulse_counter: PASSED **");
        end else begin
            $display("** input_capture_and_pulse_counter: FAILED **");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(TimeoutCycles * ClkPeriodNs);
        $display("[%0t] ERROR: timeout", $time);
        $display("** input_capture_and_pulse_counter: FAILED **");
        $finish;
    end

endmodule
